[rtl/rsds_pkg.sv]
// ----------------------------------------------------------------------------
// Route segment drive sequencer package
// Field widths, operation and register codes, reset values and the
// saturation helper shared by the channel interfaces and the datapath.
// ----------------------------------------------------------------------------
package rsds_pkg;

  localparam int MAX_ENTRIES_DEF = 32;

  // Beat field widths.
  localparam int OP_W    = 2;
  localparam int SLOT_W  = 5;
  localparam int DIST_W  = 18;
  localparam int TURN_W  = 16;
  localparam int COUNT_W = 24;
  localparam int SPEED_W = 16;
  localparam int ENTRY_W = 6;

  // Configuration port and register widths.
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 20;
  localparam int GAIN_W     = 20;
  localparam int SLOPE_W    = 16;
  localparam int SPD_CFG_W  = 15;
  localparam int RLEN_W     = 17;
  localparam int SEG_W      = 6;

  // Register reset values.
  localparam logic [GAIN_W-1:0]    BALANCE_GAIN_RST = GAIN_W'(41943);
  localparam logic [SLOPE_W-1:0]   RAMP_SLOPE_RST   = SLOPE_W'(6291);
  localparam logic [SPD_CFG_W-1:0] RAMP_OFFSET_RST  = SPD_CFG_W'(2458);
  localparam logic [SPD_CFG_W-1:0] CRUISE_RST       = SPD_CFG_W'(14746);
  localparam logic [RLEN_W-1:0]    RAMP_LENGTH_RST  = RLEN_W'(2000);
  localparam logic [SPD_CFG_W-1:0] TURN_FAST_RST    = SPD_CFG_W'(4915);
  localparam logic [SPD_CFG_W-1:0] TURN_SLOW_RST    = SPD_CFG_W'(1638);
  localparam logic [SEG_W-1:0]     SEG_COUNT_RST    = SEG_W'(1);

  // Slow spin starts this many pulses before the turn target.
  localparam int TURN_NEAR = 500;

  // Q0.24 gain times pulses brought to Q2.14.
  localparam int FRAC_SHIFT = 10;

  // Width of the argument of the saturation helper.
  localparam int SAT_W = 40;

  typedef enum logic [OP_W-1:0] {
    OP_LOAD  = 2'd0,
    OP_TICK  = 2'd1,
    OP_START = 2'd2,
    OP_STOP  = 2'd3
  } op_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_BALANCE_GAIN = 3'd0,
    CFG_RAMP_SLOPE   = 3'd1,
    CFG_RAMP_OFFSET  = 3'd2,
    CFG_CRUISE_SPEED = 3'd3,
    CFG_RAMP_LENGTH  = 3'd4,
    CFG_TURN_FAST    = 3'd5,
    CFG_TURN_SLOW    = 3'd6,
    CFG_SEG_COUNT    = 3'd7
  } cfg_idx_t;

  typedef logic signed [SPEED_W-1:0] speed_t;
  typedef logic signed [COUNT_W-1:0] count_t;

  function automatic speed_t sat16(input logic signed [SAT_W-1:0] x);
    speed_t r;
    if (x > SAT_W'(32767)) begin
      r = speed_t'(32767);
    end else if (x < -SAT_W'(32768)) begin
      r = speed_t'(-32768);
    end else begin
      r = x[SPEED_W-1:0];
    end
    return r;
  endfunction

endpackage

[rtl/rsds_in_if.sv]
// ----------------------------------------------------------------------------
// Input channel
// One beat carries an operation, a route entry for loads and both encoder
// counts for ticks.
// ----------------------------------------------------------------------------
interface rsds_in_if import rsds_pkg::*; ();

  logic                      valid;
  logic                      ready;
  op_t                       op;
  logic [SLOT_W-1:0]         entry_slot;
  logic [DIST_W-1:0]         entry_distance;
  logic signed [TURN_W-1:0]  entry_turn;
  count_t                    left_count;
  count_t                    right_count;

  modport source (
    output valid, op, entry_slot, entry_distance, entry_turn, left_count, right_count,
    input  ready
  );

  modport sink (
    input  valid, op, entry_slot, entry_distance, entry_turn, left_count, right_count,
    output ready
  );

endinterface

[rtl/rsds_out_if.sv]
// ----------------------------------------------------------------------------
// Result channel
// One beat carries both motor commands and the sequencer status after the
// step.
// ----------------------------------------------------------------------------
interface rsds_out_if import rsds_pkg::*; ();

  logic               valid;
  logic               ready;
  speed_t             left_speed;
  speed_t             right_speed;
  logic               speeds_written;
  logic               reset_encoders;
  logic               route_running;
  logic [ENTRY_W-1:0] current_entry;
  logic               in_turn;

  modport source (
    output valid, left_speed, right_speed, speeds_written, reset_encoders,
           route_running, current_entry, in_turn,
    input  ready
  );

  modport sink (
    input  valid, left_speed, right_speed, speeds_written, reset_encoders,
           route_running, current_entry, in_turn,
    output ready
  );

endinterface

[rtl/rsds_cfg_if.sv]
// ----------------------------------------------------------------------------
// Configuration write channel
// One beat writes one register, selected by index.
// ----------------------------------------------------------------------------
interface rsds_cfg_if import rsds_pkg::*; ();

  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);

endinterface

[rtl/rsds_ram.sv]
// ----------------------------------------------------------------------------
// Generic simple dual-port RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module rsds_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[rtl/route_segment_drive_sequencer.sv]
// ----------------------------------------------------------------------------
// Route segment drive sequencer
// Steps a two-wheel drive through a table of route entries: ramped straight
// drive with a balance correction, then a spin turn, entry after entry.
// ----------------------------------------------------------------------------
// Pipeline: the table is read at the accepting edge, then the beat passes the
//   decision, multiply, scale and output registers in turn.
// Throughput: one beat per cycle unless out_ch stalls; each beat reads the table
//   at the entry position the beat ahead of it leaves, so no bubbles are needed.
// Reset: control state and registers go to their defaults at once; the route
//   table is not cleared and holds garbage until loaded.
// ----------------------------------------------------------------------------
module route_segment_drive_sequencer import rsds_pkg::*; #(
  parameter int MAX_ENTRIES = MAX_ENTRIES_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  rsds_in_if.sink    in_ch,
  rsds_out_if.source out_ch,
  rsds_cfg_if.sink   cfg_ch
);

  localparam int AW     = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int CW     = (AW + 1 > SEG_W) ? AW + 1 : SEG_W;
  localparam int WORD_W = DIST_W + TURN_W;
  localparam int P_W    = COUNT_W + 1;
  localparam int RP_W   = SLOPE_W + 1 + P_W;
  localparam int CP_W   = GAIN_W + 1 + P_W;
  localparam int CORR_W = SPEED_W + 2;
  localparam int SUM_W  = CORR_W + 1;

  typedef enum logic [1:0] {
    MODE_ZERO   = 2'd0,
    MODE_DIRECT = 2'd1,
    MODE_RAMP   = 2'd2,
    MODE_CRUISE = 2'd3
  } mode_t;

  typedef struct packed {
    logic               written;
    logic               enc_rst;
    logic               running;
    logic [ENTRY_W-1:0] entry;
    logic               turn;
  } status_t;

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  logic [GAIN_W-1:0]    balance_gain_r;
  logic [SLOPE_W-1:0]   ramp_slope_r;
  logic [SPD_CFG_W-1:0] ramp_offset_r;
  logic [SPD_CFG_W-1:0] cruise_speed_r;
  logic [RLEN_W-1:0]    ramp_length_r;
  logic [SPD_CFG_W-1:0] turn_fast_r;
  logic [SPD_CFG_W-1:0] turn_slow_r;
  logic [SEG_W-1:0]     seg_count_r;

  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      balance_gain_r <= BALANCE_GAIN_RST;
      ramp_slope_r   <= RAMP_SLOPE_RST;
      ramp_offset_r  <= RAMP_OFFSET_RST;
      cruise_speed_r <= CRUISE_RST;
      ramp_length_r  <= RAMP_LENGTH_RST;
      turn_fast_r    <= TURN_FAST_RST;
      turn_slow_r    <= TURN_SLOW_RST;
      seg_count_r    <= SEG_COUNT_RST;
    end else if (cfg_ch.valid) begin
      unique case (cfg_idx_t'(cfg_ch.index))
        CFG_BALANCE_GAIN: balance_gain_r <= cfg_ch.data[GAIN_W-1:0];
        CFG_RAMP_SLOPE:   ramp_slope_r   <= cfg_ch.data[SLOPE_W-1:0];
        CFG_RAMP_OFFSET:  ramp_offset_r  <= cfg_ch.data[SPD_CFG_W-1:0];
        CFG_CRUISE_SPEED: cruise_speed_r <= cfg_ch.data[SPD_CFG_W-1:0];
        CFG_RAMP_LENGTH:  ramp_length_r  <= cfg_ch.data[RLEN_W-1:0];
        CFG_TURN_FAST:    turn_fast_r    <= cfg_ch.data[SPD_CFG_W-1:0];
        CFG_TURN_SLOW:    turn_slow_r    <= cfg_ch.data[SPD_CFG_W-1:0];
        CFG_SEG_COUNT:    seg_count_r    <= cfg_ch.data[SEG_W-1:0];
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Pipeline flow control
  // ---------------------------------------------------------------------------
  logic st1_v_r, st2_v_r, st3_v_r, st4_v_r, out_v_r;
  logic st1_free, st2_free, st3_free, st4_free, out_free;
  logic in_acc;

  assign out_free = !out_v_r || out_ch.ready;
  assign st4_free = !st4_v_r || out_free;
  assign st3_free = !st3_v_r || st4_free;
  assign st2_free = !st2_v_r || st3_free;
  assign st1_free = !st1_v_r || st2_free;

  assign in_ch.ready = st1_free;
  assign in_acc      = in_ch.valid && st1_free;

  // ---------------------------------------------------------------------------
  // Sequencer state and route table
  // ---------------------------------------------------------------------------
  logic [AW-1:0] pos_r, pos_nxt;
  logic          turn_r, turn_nxt;
  logic          active_r, active_nxt;
  logic          st_upd;

  logic          tbl_we;
  logic [WORD_W-1:0] tbl_q;

  // Loads write at accept; every later beat reads after that edge, so a
  // tick right behind a load to its entry sees the new data.
  assign tbl_we = in_acc && (in_ch.op == OP_LOAD) && (int'(in_ch.entry_slot) < MAX_ENTRIES);

  rsds_ram #(
    .WIDTH (WORD_W),
    .DEPTH (MAX_ENTRIES),
    .AW    (AW)
  ) u_route_tbl (
    .clk   (clk),
    .we    (tbl_we),
    .waddr (AW'(in_ch.entry_slot)),
    .wdata ({in_ch.entry_distance, in_ch.entry_turn}),
    .re    (in_acc),
    .raddr (pos_nxt),
    .rdata (tbl_q)
  );

  // Stage 1: accepted beat, table entry arrives from the RAM.
  op_t    st1_op_r;
  op_t    st1_op;
  count_t st1_lc_r, st1_rc_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st1_v_r <= 1'b0;
    end else if (st1_free) begin
      st1_v_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (st1_free) begin
      st1_op_r <= in_ch.op;
      st1_lc_r <= in_ch.left_count;
      st1_rc_r <= in_ch.right_count;
    end
  end

  assign st1_op = st1_op_r;

  // Decision for the beat in stage 1.
  logic signed [P_W-1:0] lc_x, rc_x, al, ar, d_x, rl_x, a_x, aa, near;
  logic                  d_gt_lc, long_seg, lt_rl, in_tail, first_half;
  logic                  slow, lgo, rgo;
  logic [SPD_CFG_W-1:0]  spin;
  speed_t                spin_p, spin_n;
  logic [CW-1:0]         seg_x, cnt_eff, pos_inc;
  logic [AW-1:0]         dec_pos;
  logic                  dec_turn, dec_active;
  mode_t                 dec_mode;
  logic signed [P_W-1:0] dec_p;
  speed_t                dec_ls, dec_rs;
  status_t               dec_stat;

  always_comb begin
    lc_x = P_W'(st1_lc_r);
    rc_x = P_W'(st1_rc_r);
    al   = lc_x[P_W-1] ? -lc_x : lc_x;
    ar   = rc_x[P_W-1] ? -rc_x : rc_x;
    d_x  = $signed(P_W'(tbl_q[WORD_W-1:TURN_W]));
    rl_x = $signed(P_W'(ramp_length_r));
    a_x  = P_W'($signed(tbl_q[TURN_W-1:0]));
    aa   = a_x[P_W-1] ? -a_x : a_x;
    near = aa - P_W'(TURN_NEAR);

    d_gt_lc    = d_x > lc_x;
    long_seg   = d_x > (rl_x + rl_x);
    lt_rl      = lc_x < rl_x;
    in_tail    = (d_x - rl_x) < lc_x;
    first_half = d_x > (lc_x + lc_x);

    slow   = (near < al) || (near < ar);
    lgo    = aa > al;
    rgo    = aa > ar;
    spin   = slow ? turn_slow_r : turn_fast_r;
    spin_p = $signed({1'b0, spin});
    spin_n = -spin_p;

    seg_x = CW'(seg_count_r);
    if (seg_x == '0) begin
      cnt_eff = CW'(1);
    end else if (seg_x > CW'(MAX_ENTRIES)) begin
      cnt_eff = CW'(MAX_ENTRIES);
    end else begin
      cnt_eff = seg_x;
    end
    pos_inc = CW'(pos_r) + CW'(1);

    dec_pos          = pos_r;
    dec_turn         = turn_r;
    dec_active       = active_r;
    dec_mode         = MODE_ZERO;
    dec_p            = lc_x;
    dec_ls           = '0;
    dec_rs           = '0;
    dec_stat.written = 1'b0;
    dec_stat.enc_rst = 1'b0;

    unique case (st1_op)
      OP_LOAD: ;
      OP_START: begin
        dec_stat.enc_rst = 1'b1;
        if (!active_r) begin
          dec_pos  = '0;
          dec_turn = 1'b0;
        end
        dec_active = 1'b1;
      end
      OP_STOP: begin
        dec_active = 1'b0;
        dec_turn   = 1'b0;
      end
      OP_TICK: begin
        if (active_r) begin
          dec_stat.written = 1'b1;
          if (!turn_r) begin
            if (d_gt_lc) begin
              // Long entries rise, cruise and fall; short ones form a triangle.
              dec_mode = MODE_RAMP;
              if (long_seg) begin
                if (lt_rl) begin
                  dec_p = lc_x;
                end else if (in_tail) begin
                  dec_p = d_x - lc_x;
                end else begin
                  dec_mode = MODE_CRUISE;
                end
              end else begin
                dec_p = first_half ? lc_x : d_x - lc_x;
              end
            end else begin
              dec_stat.enc_rst = 1'b1;
              if (pos_inc >= cnt_eff) begin
                dec_active = 1'b0;
                dec_turn   = 1'b0;
              end else begin
                dec_turn = 1'b1;
              end
            end
          end else begin
            if (lgo || rgo) begin
              // A negative turn spins right: left forward, right backward.
              dec_mode = MODE_DIRECT;
              dec_ls   = lgo ? (a_x[P_W-1] ? spin_p : spin_n) : '0;
              dec_rs   = rgo ? (a_x[P_W-1] ? spin_n : spin_p) : '0;
            end else begin
              dec_stat.enc_rst = 1'b1;
              if (pos_inc < CW'(MAX_ENTRIES)) begin
                dec_pos = pos_inc[AW-1:0];
              end
              dec_turn = 1'b0;
            end
          end
        end
      end
      default: ;
    endcase

    dec_stat.running = dec_active;
    dec_stat.entry   = ENTRY_W'(dec_pos);
    dec_stat.turn    = dec_turn;
  end

  assign st_upd     = st1_v_r && st2_free;
  assign pos_nxt    = st_upd ? dec_pos : pos_r;
  assign turn_nxt   = st_upd ? dec_turn : turn_r;
  assign active_nxt = st_upd ? dec_active : active_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r    <= '0;
      turn_r   <= 1'b0;
      active_r <= 1'b0;
    end else begin
      pos_r    <= pos_nxt;
      turn_r   <= turn_nxt;
      active_r <= active_nxt;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 2: selected pulse count and count difference
  // ---------------------------------------------------------------------------
  mode_t                 st2_mode_r;
  logic signed [P_W-1:0] st2_p_r, st2_diff_r;
  speed_t                st2_ls_r, st2_rs_r;
  status_t               st2_stat_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st2_v_r <= 1'b0;
    end else if (st2_free) begin
      st2_v_r <= st1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (st2_free) begin
      st2_mode_r <= dec_mode;
      st2_p_r    <= dec_p;
      st2_diff_r <= al - ar;
      st2_ls_r   <= dec_ls;
      st2_rs_r   <= dec_rs;
      st2_stat_r <= dec_stat;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 3: ramp and balance products
  // ---------------------------------------------------------------------------
  mode_t                  st3_mode_r;
  logic signed [RP_W-1:0] st3_rprod_r;
  logic signed [CP_W-1:0] st3_cprod_r;
  speed_t                 st3_ls_r, st3_rs_r;
  status_t                st3_stat_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st3_v_r <= 1'b0;
    end else if (st3_free) begin
      st3_v_r <= st2_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (st3_free) begin
      st3_mode_r  <= st2_mode_r;
      st3_rprod_r <= $signed({1'b0, ramp_slope_r}) * st2_p_r;
      st3_cprod_r <= $signed({1'b0, balance_gain_r}) * st2_diff_r;
      st3_ls_r    <= st2_ls_r;
      st3_rs_r    <= st2_rs_r;
      st3_stat_r  <= st2_stat_r;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 4: scale to Q2.14, saturate the ramp, clamp the correction
  // ---------------------------------------------------------------------------
  logic signed [RP_W-1:0]   ramp_sum;
  speed_t                   ramp_sat, drive_sp;
  logic signed [CP_W-1:0]   corr_full;
  logic signed [CORR_W-1:0] corr_clamp;
  speed_t                   s4_ls, s4_rs;
  logic                     s4_add;

  always_comb begin
    // Arithmetic shift rounds toward minus infinity.
    ramp_sum  = (st3_rprod_r >>> FRAC_SHIFT) + $signed(RP_W'(ramp_offset_r));
    ramp_sat  = sat16(SAT_W'(ramp_sum));
    corr_full = st3_cprod_r >>> FRAC_SHIFT;
    // Any correction beyond 17 bits saturates the right speed anyway.
    if (corr_full > CP_W'(65535)) begin
      corr_clamp = CORR_W'(65535);
    end else if (corr_full < -CP_W'(65536)) begin
      corr_clamp = CORR_W'(-65536);
    end else begin
      corr_clamp = corr_full[CORR_W-1:0];
    end
    drive_sp = (st3_mode_r == MODE_CRUISE) ? $signed({1'b0, cruise_speed_r}) : ramp_sat;

    unique case (st3_mode_r)
      MODE_ZERO: begin
        s4_ls  = '0;
        s4_rs  = '0;
        s4_add = 1'b0;
      end
      MODE_DIRECT: begin
        s4_ls  = st3_ls_r;
        s4_rs  = st3_rs_r;
        s4_add = 1'b0;
      end
      MODE_RAMP, MODE_CRUISE: begin
        s4_ls  = drive_sp;
        s4_rs  = drive_sp;
        s4_add = 1'b1;
      end
      default: begin
        s4_ls  = '0;
        s4_rs  = '0;
        s4_add = 1'b0;
      end
    endcase
  end

  speed_t                   st4_ls_r, st4_rs_r;
  logic signed [CORR_W-1:0] st4_corr_r;
  logic                     st4_add_r;
  status_t                  st4_stat_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st4_v_r <= 1'b0;
    end else if (st4_free) begin
      st4_v_r <= st3_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (st4_free) begin
      st4_ls_r   <= s4_ls;
      st4_rs_r   <= s4_rs;
      st4_corr_r <= corr_clamp;
      st4_add_r  <= s4_add;
      st4_stat_r <= st3_stat_r;
    end
  end

  // ---------------------------------------------------------------------------
  // Output register: balance correction on the right wheel
  // ---------------------------------------------------------------------------
  logic signed [SUM_W-1:0] rs_sum;
  speed_t                  rs_fin;
  speed_t                  out_ls_r, out_rs_r;
  status_t                 out_stat_r;

  assign rs_sum = SUM_W'(st4_rs_r) + SUM_W'(st4_corr_r);
  assign rs_fin = st4_add_r ? sat16(SAT_W'(rs_sum)) : st4_rs_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (out_free) begin
      out_v_r <= st4_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free) begin
      out_ls_r   <= st4_ls_r;
      out_rs_r   <= rs_fin;
      out_stat_r <= st4_stat_r;
    end
  end

  assign out_ch.valid          = out_v_r;
  assign out_ch.left_speed     = out_ls_r;
  assign out_ch.right_speed    = out_rs_r;
  assign out_ch.speeds_written = out_stat_r.written;
  assign out_ch.reset_encoders = out_stat_r.enc_rst;
  assign out_ch.route_running  = out_stat_r.running;
  assign out_ch.current_entry  = out_stat_r.entry;
  assign out_ch.in_turn        = out_stat_r.turn;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  // The turn phase only exists inside a running route.
  a_turn_in_run: assert property (@(posedge clk) disable iff (!rst_n)
    turn_r |-> active_r)
    else $error("turn phase set while route is not running");

  // Sequencer state moves only when the beat in stage 1 advances.
  a_state_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !st_upd |=> $stable({pos_r, turn_r, active_r}))
    else $error("sequencer state changed without a beat advancing");

  // A beat that does not command the motors carries zero speeds.
  a_unwritten_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_v_r && !out_stat_r.written |-> (out_ls_r == '0) && (out_rs_r == '0))
    else $error("speeds nonzero on a beat that does not write them");

  // A completed phase stops both motors.
  a_phase_end_stop: assert property (@(posedge clk) disable iff (!rst_n)
    out_v_r && out_stat_r.written && out_stat_r.enc_rst
      |-> (out_ls_r == '0) && (out_rs_r == '0))
    else $error("motors not stopped at phase completion");

endmodule

[dv/tb_route_segment_drive_sequencer.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Route segment drive sequencer testbench
// Loads route tables, starts runs and feeds encoder ticks that walk each
// entry through its drive and turn phases, with some noise mixed in. Every
// result beat is checked against a cycle-free model of the sequencer that is
// kept up to date as input beats are accepted.
// ----------------------------------------------------------------------------
module tb_route_segment_drive_sequencer;
  import rsds_pkg::*;

  localparam int SLOTS        = 32;
  localparam int NEAR_PULSES  = 500;
  localparam int ITEM_TARGET  = 1400;
  localparam int CYCLE_LIMIT  = 1000000;
  localparam int MAX_REPORTS  = 10;

  typedef struct packed {
    op_t                      op;
    logic [SLOT_W-1:0]        slot;
    logic [DIST_W-1:0]        len;
    logic signed [TURN_W-1:0] turn;
    count_t                   lc;
    count_t                   rc;
  } drive_cmd_t;

  typedef struct packed {
    speed_t             left_speed;
    speed_t             right_speed;
    logic               written;
    logic               enc_reset;
    logic               running;
    logic [ENTRY_W-1:0] entry;
    logic               turning;
  } motor_status_t;

  // Tracks the sequencer state and queues the status beat each input causes.
  class drive_scoreboard;
    longint        route_len[SLOTS];
    longint        route_turn[SLOTS];
    bit            loaded[SLOTS];
    int            entry_pos;
    bit            in_turn_phase;
    bit            route_active;
    bit            last_enc_reset;
    longint        gain, slope, offset, cruise, rlen, tfast, tslow, segs;
    motor_status_t status_q[$];
    int            mismatches;

    function new();
      entry_pos = 0;
      in_turn_phase = 0;
      route_active = 0;
      last_enc_reset = 0;
      mismatches = 0;
      foreach (loaded[i]) loaded[i] = 0;
      gain = 41943;
      slope = 6291;
      offset = 2458;
      cruise = 14746;
      rlen = 2000;
      tfast = 4915;
      tslow = 1638;
      segs = 1;
    endfunction

    function longint floor_q14(longint x);
      return x >>> 10;
    endfunction

    function longint clip16(longint x);
      if (x > 32767) return 32767;
      if (x < -32768) return -32768;
      return x;
    endfunction

    function longint mag(longint x);
      return (x < 0) ? -x : x;
    endfunction

    function longint ramp_at(longint pulses);
      return clip16(floor_q14(slope * pulses) + offset);
    endfunction

    // Rise, cruise and fall on long entries; a triangle on short ones.
    function longint profile_speed(longint d, longint left);
      if (d > 2 * rlen) begin
        if (left < rlen) return ramp_at(left);
        if (d - rlen < left) return ramp_at(d - left);
        return cruise;
      end
      if (d > 2 * left) return ramp_at(left);
      return ramp_at(d - left);
    endfunction

    function void set_reg(cfg_idx_t idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        CFG_BALANCE_GAIN: gain   = longint'(data[GAIN_W-1:0]);
        CFG_RAMP_SLOPE:   slope  = longint'(data[SLOPE_W-1:0]);
        CFG_RAMP_OFFSET:  offset = longint'(data[SPD_CFG_W-1:0]);
        CFG_CRUISE_SPEED: cruise = longint'(data[SPD_CFG_W-1:0]);
        CFG_RAMP_LENGTH:  rlen   = longint'(data[RLEN_W-1:0]);
        CFG_TURN_FAST:    tfast  = longint'(data[SPD_CFG_W-1:0]);
        CFG_TURN_SLOW:    tslow  = longint'(data[SPD_CFG_W-1:0]);
        CFG_SEG_COUNT:    segs   = longint'(data[SEG_W-1:0]);
      endcase
    endfunction

    function void note_input(drive_cmd_t c);
      motor_status_t e;
      longint ls, rs, lc, rc, al, ar, d, sp, corr, a, aa, s, dir, cnt;
      e = '0;
      ls = 0;
      rs = 0;
      case (c.op)
        OP_LOAD: begin
          route_len[c.slot] = longint'(c.len);
          route_turn[c.slot] = longint'($signed(c.turn));
          loaded[c.slot] = 1;
        end
        OP_START: begin
          e.enc_reset = 1;
          if (!route_active) begin
            entry_pos = 0;
            in_turn_phase = 0;
          end
          route_active = 1;
        end
        OP_STOP: begin
          route_active = 0;
          in_turn_phase = 0;
        end
        OP_TICK: begin
          if (route_active) begin
            lc = longint'($signed(c.lc));
            rc = longint'($signed(c.rc));
            al = mag(lc);
            ar = mag(rc);
            cnt = (segs < 1) ? 1 : ((segs > SLOTS) ? SLOTS : segs);
            e.written = 1;
            if (!in_turn_phase) begin
              d = route_len[entry_pos];
              if (d > lc) begin
                sp = profile_speed(d, lc);
                corr = floor_q14((al - ar) * gain);
                ls = sp;
                rs = clip16(sp + corr);
              end else begin
                // The run ends after the drive of the last entry in use.
                e.enc_reset = 1;
                if (entry_pos + 1 >= cnt) begin
                  route_active = 0;
                  in_turn_phase = 0;
                end else begin
                  in_turn_phase = 1;
                end
              end
            end else begin
              a = route_turn[entry_pos];
              aa = mag(a);
              s = tfast;
              if (aa - NEAR_PULSES < al || aa - NEAR_PULSES < ar) s = tslow;
              if (aa > al || aa > ar) begin
                dir = (a < 0) ? 1 : -1;
                ls = (aa > al) ? dir * s : 0;
                rs = (aa > ar) ? -dir * s : 0;
              end else begin
                e.enc_reset = 1;
                if (entry_pos + 1 < SLOTS) entry_pos = entry_pos + 1;
                in_turn_phase = 0;
              end
            end
          end
        end
      endcase
      e.left_speed = speed_t'(ls);
      e.right_speed = speed_t'(rs);
      e.running = route_active;
      e.entry = ENTRY_W'(entry_pos);
      e.turning = in_turn_phase;
      last_enc_reset = e.enc_reset;
      status_q.push_back(e);
    endfunction

    function void check_result(motor_status_t got);
      motor_status_t exp_st;
      bit bad;
      if (status_q.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("[%0t] result beat with nothing pending", $realtime);
        return;
      end
      exp_st = status_q.pop_front();
      bad = (got.left_speed !== exp_st.left_speed) ||
            (got.right_speed !== exp_st.right_speed) ||
            (got.written !== exp_st.written) ||
            (got.enc_reset !== exp_st.enc_reset) ||
            (got.running !== exp_st.running) ||
            (got.entry !== exp_st.entry) ||
            (got.turning !== exp_st.turning);
      if (bad) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS) begin
          $display("[%0t] status mismatch", $realtime);
          $display("  expected L=%0d R=%0d wr=%0b enc=%0b run=%0b entry=%0d turn=%0b",
                   exp_st.left_speed, exp_st.right_speed, exp_st.written,
                   exp_st.enc_reset, exp_st.running, exp_st.entry, exp_st.turning);
          $display("  actual   L=%0d R=%0d wr=%0b enc=%0b run=%0b entry=%0d turn=%0b",
                   got.left_speed, got.right_speed, got.written,
                   got.enc_reset, got.running, got.entry, got.turning);
        end
      end
    endfunction

    function int outstanding();
      return status_q.size();
    endfunction
  endclass

  logic clk;
  logic rst_n;

  rsds_in_if  in_ch();
  rsds_out_if out_ch();
  rsds_cfg_if cfg_ch();

  drive_scoreboard sb = new();

  longint enc_l;
  longint enc_r;
  int     sent_items;
  bit     send_fast;

  route_segment_drive_sequencer #(
    .MAX_ENTRIES(SLOTS)
  ) i_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin : watchdog
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("Verification failed");
    $finish;
  end

  function automatic drive_cmd_t rand_cmd(op_t op);
    drive_cmd_t c;
    c.op = op;
    c.slot = SLOT_W'($urandom);
    c.len = DIST_W'($urandom);
    c.turn = TURN_W'($urandom);
    c.lc = COUNT_W'($urandom);
    c.rc = COUNT_W'($urandom);
    return c;
  endfunction

  function automatic drive_cmd_t load_cmd(int slot, int seg_len, int turn);
    drive_cmd_t c;
    c = rand_cmd(OP_LOAD);
    c.slot = SLOT_W'(slot);
    c.len = DIST_W'(seg_len);
    c.turn = TURN_W'(turn);
    return c;
  endfunction

  function automatic drive_cmd_t random_entry(int slot);
    int seg_len, turn, r;
    r = $urandom_range(0, 19);
    if (r == 0) seg_len = int'(DIST_W'($urandom));
    else if (r == 1) seg_len = $urandom_range(0, 8);
    else if (r < 5) seg_len = $urandom_range(3000, 20000);
    else seg_len = $urandom_range(0, 3000);
    r = $urandom_range(0, 9);
    if (r < 2) turn = int'($signed(TURN_W'($urandom)));
    else if (r < 5) turn = $urandom_range(0, 600);
    else turn = $urandom_range(0, 3000);
    if (r >= 2 && $urandom_range(0, 1) == 1) turn = -turn;
    return load_cmd(slot, seg_len, turn);
  endfunction

  function automatic int route_span();
    if (sb.segs == 0) return 1;
    if (sb.segs > SLOTS) return SLOTS;
    return int'(sb.segs);
  endfunction

  task automatic send_cmd(drive_cmd_t c);
    int gap;
    bit counts;
    if ($urandom_range(0, 39) == 0) send_fast = !send_fast;
    gap = send_fast ? 0 : $urandom_range(0, 10);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid          <= 1'b1;
    in_ch.op             <= c.op;
    in_ch.entry_slot     <= c.slot;
    in_ch.entry_distance <= c.len;
    in_ch.entry_turn     <= c.turn;
    in_ch.left_count     <= c.lc;
    in_ch.right_count    <= c.rc;
    do @(posedge clk); while (!in_ch.ready);
    counts = (c.op != OP_TICK) || sb.route_active;
    if (counts) sent_items++;
    sb.note_input(c);
    if (sb.last_enc_reset) begin
      enc_l = 0;
      enc_r = 0;
    end
  endtask

  // A tick never reads an entry that was not loaded; such a slot is loaded first.
  task automatic send_tick(longint l, longint r);
    drive_cmd_t c;
    if (sb.route_active && !sb.loaded[sb.entry_pos]) send_cmd(random_entry(sb.entry_pos));
    c = rand_cmd(OP_TICK);
    c.lc = COUNT_W'(l);
    c.rc = COUNT_W'(r);
    send_cmd(c);
  endtask

  task automatic wait_idle();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (sb.outstanding() != 0) @(posedge clk);
  endtask

  task automatic write_reg(cfg_idx_t idx, logic [CFG_DATA_W-1:0] data);
    if ($urandom_range(0, 2) == 0) begin
      cfg_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk);
    end
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= data;
    do @(posedge clk); while (!cfg_ch.ready);
    sb.set_reg(idx, data);
  endtask

  function automatic logic [CFG_DATA_W-1:0] reg_value(cfg_idx_t idx);
    logic [CFG_DATA_W-1:0] v, m;
    int w, r;
    case (idx)
      CFG_BALANCE_GAIN: w = GAIN_W;
      CFG_RAMP_SLOPE:   w = SLOPE_W;
      CFG_RAMP_LENGTH:  w = RLEN_W;
      CFG_SEG_COUNT:    w = SEG_W;
      default:          w = SPD_CFG_W;
    endcase
    m = (CFG_DATA_W'(1) << w) - CFG_DATA_W'(1);
    v = CFG_DATA_W'($urandom);
    r = $urandom_range(0, 19);
    if (idx == CFG_SEG_COUNT) begin
      // Mostly short routes; zero and counts past the table size now and then.
      v = v & ~m;
      if (r < 2) v = v | CFG_DATA_W'(0);
      else if (r == 2) v = v | CFG_DATA_W'($urandom_range(33, 63));
      else if (r == 3) v = v | CFG_DATA_W'(SLOTS);
      else v = v | CFG_DATA_W'($urandom_range(1, 4));
    end else if (r < 3) begin
      v = v & ~m;
    end else if (r < 6) begin
      v = v | m;
    end else if (r < 12) begin
      v = (v & ~m) | CFG_DATA_W'($urandom_range(0, 4000));
    end
    return v;
  endfunction

  task automatic configure(bit every_reg);
    cfg_idx_t idx;
    idx = idx.first();
    do begin
      if (every_reg || $urandom_range(0, 2) == 0) write_reg(idx, reg_value(idx));
      idx = idx.next();
    end while (idx != idx.first());
    cfg_ch.valid <= 1'b0;
  endtask

  task automatic run_directed();
    send_tick(1000, -2000);
    send_cmd(load_cmd(0, 262143, -32768));
    send_cmd(load_cmd(31, 0, 32767));
    send_cmd(load_cmd(1, 1500, 700));
    send_cmd(load_cmd(2, 3000, -400));
    send_cmd(rand_cmd(OP_START));
    send_tick(0, 0);
    send_tick(1000, -8388608);
    send_tick(-8388608, 0);
    send_tick(130000, 130000);
    send_tick(261000, 261050);
    send_cmd(rand_cmd(OP_START));
    send_tick(8388607, 8388607);
    send_tick(5, 5);
    send_cmd(rand_cmd(OP_STOP));
    wait_idle();
    write_reg(CFG_SEG_COUNT, CFG_DATA_W'(3));
    write_reg(CFG_RAMP_LENGTH, CFG_DATA_W'(0));
    write_reg(CFG_TURN_FAST, CFG_DATA_W'(32767));
    write_reg(CFG_TURN_SLOW, CFG_DATA_W'(0));
    cfg_ch.valid <= 1'b0;
    send_cmd(rand_cmd(OP_START));
    send_tick(262143, 262143);
    send_tick(0, 0);
    send_tick(32768, -32300);
    send_tick(40000, -32768);
    send_tick(1500, 1500);
    send_cmd(rand_cmd(OP_STOP));
    send_cmd(rand_cmd(OP_START));
    send_cmd(rand_cmd(OP_STOP));
  endtask

  // Encoder counts follow the commanded motion so that runs get deep into
  // the route; a fraction of beats are stops, restarts, reloads and wild counts.
  task automatic run_route(bit every_reg);
    int span, budget, r;
    longint d, aa, a;
    wait_idle();
    configure(every_reg);
    span = route_span();
    for (int s = 0; s < span; s++) send_cmd(random_entry(s));
    if ($urandom_range(0, 3) == 0) send_cmd(random_entry($urandom_range(0, SLOTS - 1)));
    send_cmd(rand_cmd(OP_START));
    budget = $urandom_range(20, 150);
    while (sb.route_active && budget > 0) begin
      budget--;
      r = $urandom_range(0, 99);
      if (r < 2) begin
        send_cmd(rand_cmd(OP_STOP));
      end else if (r < 4) begin
        send_cmd(rand_cmd(OP_START));
      end else if (r < 7) begin
        send_cmd(random_entry($urandom_range(0, SLOTS - 1)));
      end else if (r < 12) begin
        send_tick(longint'($signed(COUNT_W'($urandom))), longint'($signed(COUNT_W'($urandom))));
      end else if (!sb.in_turn_phase) begin
        d = sb.route_len[sb.entry_pos];
        if ($urandom_range(0, 9) == 0) enc_l = d;
        else enc_l = enc_l + longint'($urandom_range(0, int'(d / 6) + 3));
        enc_r = enc_l + longint'(int'($urandom_range(0, 40)) - 20);
        send_tick(enc_l, enc_r);
      end else begin
        a = sb.route_turn[sb.entry_pos];
        aa = (a < 0) ? -a : a;
        enc_l = enc_l + longint'($urandom_range(0, int'(aa / 5) + 3));
        enc_r = enc_r + longint'($urandom_range(0, int'(aa / 5) + 3));
        if (a < 0) send_tick(enc_l, -enc_r);
        else send_tick(-enc_l, enc_r);
      end
    end
    if (sb.route_active && $urandom_range(0, 1) == 1) send_cmd(rand_cmd(OP_STOP));
    if ($urandom_range(0, 3) == 0) send_tick(enc_l, enc_r);
  endtask

  initial begin : result_sink
    int            stall;
    int            got_beats;
    bit            fast;
    motor_status_t r;
    got_beats = 0;
    fast = 0;
    out_ch.ready <= 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      // Long hold-offs let the sender fill the block until it stalls.
      if (got_beats == 150 || got_beats == 900) begin
        out_ch.ready <= 1'b0;
        repeat (400) @(posedge clk);
      end
      if ($urandom_range(0, 39) == 0) fast = !fast;
      stall = fast ? 0 : $urandom_range(0, 10);
      if (stall > 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (!out_ch.valid);
      r.left_speed  = out_ch.left_speed;
      r.right_speed = out_ch.right_speed;
      r.written     = out_ch.speeds_written;
      r.enc_reset   = out_ch.reset_encoders;
      r.running     = out_ch.route_running;
      r.entry       = out_ch.current_entry;
      r.turning     = out_ch.in_turn;
      sb.check_result(r);
      got_beats++;
    end
  end

  initial begin : stimulus
    bit first_route;
    enc_l = 0;
    enc_r = 0;
    sent_items = 0;
    send_fast = 0;
    rst_n                <= 1'b0;
    in_ch.valid          <= 1'b0;
    in_ch.op             <= OP_TICK;
    in_ch.entry_slot     <= '0;
    in_ch.entry_distance <= '0;
    in_ch.entry_turn     <= '0;
    in_ch.left_count     <= '0;
    in_ch.right_count    <= '0;
    cfg_ch.valid         <= 1'b0;
    cfg_ch.index         <= CFG_BALANCE_GAIN;
    cfg_ch.data          <= '0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    run_directed();
    first_route = 1;
    while (sent_items < ITEM_TARGET) begin
      run_route(first_route);
      first_route = 0;
    end
    wait_idle();
    repeat (20) @(posedge clk);
    if (sb.mismatches == 0 && sb.outstanding() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
